FILE: sv/sine_cosine_polynomial_assert.svh
// Assertion macros shared by the checker of the sine/cosine block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SINE_COSINE_POLYNOMIAL_ASSERT_SVH
`define SINE_COSINE_POLYNOMIAL_ASSERT_SVH

// Same-cycle implication
`define SCP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scp: same-cycle check failed");

// Next-cycle implication
`define SCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scp: next-cycle check failed");

`endif

FILE: sv/scp_pkg.sv
`default_nettype none
package scp_pkg;

    // Default formats
    localparam int ANGLE_FRAC_BITS_DEF  = 16;
    localparam int RESULT_FRAC_BITS_DEF = 30;

    // Field and datapath widths
    localparam int ANGLE_W  = 32;
    localparam int RESULT_W = 32;
    localparam int MOD_W    = 35;   // two pi in Q.32 needs 35 bits
    localparam int PSUM_W   = 38;   // sum of eight residues
    localparam int SUM_W    = 40;   // sum of all 32 residues
    localparam int RED3_W   = 37;   // below four times two pi
    localparam int Q30_W    = 32;   // folded angle in Q2.30
    localparam int P_W      = 34;   // Horner accumulator
    localparam int T_W      = 34;   // squared angle, non-negative

    localparam int HORNER_STEPS = 5;

    // Angle constants in Q.32
    localparam logic [MOD_W-1:0] HALF_PI_Q32       = 35'h1921FB544;
    localparam logic [MOD_W-1:0] PI_Q32            = 35'h3243F6A88;
    localparam logic [MOD_W-1:0] THREE_HALF_PI_Q32 = 35'h4B65F1FCC;
    localparam logic [MOD_W-1:0] TWO_PI_Q32        = 35'h6487ED510;

    // Sine polynomial coefficients in Q2.30, highest degree first
    function automatic logic signed [Q30_W-1:0] sin_coef(input int idx);
        case (idx)
            0:       return -32'sd26;
            1:       return 32'sd2956;
            2:       return -32'sd213040;
            3:       return 32'sd8947847;
            4:       return -32'sd178956970;
            default: return 32'sd1073741824;
        endcase
    endfunction

    // Cosine polynomial coefficients in Q2.30, highest degree first
    function automatic logic signed [Q30_W-1:0] cos_coef(input int idx);
        case (idx)
            0:       return -32'sd280;
            1:       return 32'sd26587;
            2:       return -32'sd1491255;
            3:       return 32'sd44739216;
            4:       return -32'sd536870908;
            default: return 32'sd1073741824;
        endcase
    endfunction

    // Residue of 2^e modulo two pi (Q.32), by modular doubling
    function automatic logic [MOD_W-1:0] pow2_mod(input int e);
        logic [MOD_W:0] p;
        p = (MOD_W+1)'(1);
        for (int j = 0; j < e; j++)
        begin
            p = p << 1;
            if (p >= {1'b0, TWO_PI_Q32})
            begin
                p = p - {1'b0, TWO_PI_Q32};
            end
        end
        return p[MOD_W-1:0];
    endfunction

    // Folded angle leaving the reduction pipeline
    typedef struct packed {
        logic signed [Q30_W-1:0] a30;
        logic                    neg;
    } scp_angle_t;

    // Horner state carried along the polynomial pipeline
    typedef struct packed {
        logic signed [P_W-1:0]   p_sin;
        logic signed [P_W-1:0]   p_cos;
        logic signed [T_W-1:0]   t;
        logic signed [Q30_W-1:0] a30;
        logic                    neg;
    } scp_horner_t;

endpackage
`default_nettype wire

FILE: sv/sine_cosine_polynomial.sv
// Fixed-point sine and cosine: each angle beat (radians, signed, ANGLE_FRAC_BITS fraction
// bits) yields one result beat with sine and cosine in signed RESULT_FRAC_BITS format,
// saturated to 32 bits. The block is a 21-stage pipeline that takes one angle per clock
// while result_ready stays high. Stages: input register, five stages of exact modulo-two-pi
// reduction (residue sum, then compare-subtract) and fold, squaring and its rounding, two
// stages for each of the five Horner steps (both polynomials side by side), the final sine
// product, its rounding, and the output register. Each stage holds its beat while the stage
// after it is stalled and empty stages fill up, so a stalled result lets the upstream stages
// keep accepting angles until the pipeline is full. There is no state and no setup after
// reset.
`default_nettype none
module sine_cosine_polynomial #(
    parameter int ANGLE_FRAC_BITS  = scp_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int RESULT_FRAC_BITS = scp_pkg::RESULT_FRAC_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 angle_valid,
    output      logic                                 angle_ready,
    input  wire logic signed [scp_pkg::ANGLE_W-1:0]   angle,
    output      logic                                 result_valid,
    input  wire logic                                 result_ready,
    output      logic signed [scp_pkg::RESULT_W-1:0]  sine,
    output      logic signed [scp_pkg::RESULT_W-1:0]  cosine
);

    localparam int P_W    = scp_pkg::P_W;
    localparam int T_W    = scp_pkg::T_W;
    localparam int Q30_W  = scp_pkg::Q30_W;
    localparam int STEPS  = scp_pkg::HORNER_STEPS;

    // Stage positions
    localparam int ST_IN   = 0;
    localparam int ST_RED  = 1;
    localparam int ST_SQ   = 6;
    localparam int ST_T    = 7;
    localparam int ST_H0   = 8;
    localparam int ST_PROD = ST_H0 + 2 * STEPS;
    localparam int ST_S30  = ST_PROD + 1;
    localparam int ST_OUT  = ST_S30 + 1;
    localparam int NST     = ST_OUT + 1;

    localparam int SQ_W   = 2 * Q30_W;
    localparam int FIN_W  = Q30_W + P_W;
    localparam int OUT_SH = 30 - RESULT_FRAC_BITS;

    localparam logic signed [SQ_W-1:0]  RND_SQ  = SQ_W'(1) <<< 29;
    localparam logic signed [FIN_W-1:0] RND_FIN = FIN_W'(1) <<< 29;
    localparam logic signed [P_W:0]     RND_OUT = (P_W+1)'((1 << OUT_SH) >> 1);
    localparam logic signed [P_W:0]     OUT_MAX = (P_W+1)'(32'h7FFFFFFF);
    localparam logic signed [P_W:0]     OUT_MIN = -OUT_MAX - (P_W+1)'(1);

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    logic signed [scp_pkg::ANGLE_W-1:0] angle_reg;
    scp_pkg::scp_angle_t                folded;
    logic signed [SQ_W-1:0]             sq_reg;
    scp_pkg::scp_angle_t                sq_side_reg;
    logic signed [SQ_W-1:0]             t_wide;
    scp_pkg::scp_horner_t               h0_next;
    scp_pkg::scp_horner_t               h [STEPS+1];
    logic signed [FIN_W-1:0]            fin_prod_reg;
    logic signed [P_W-1:0]              fin_cos_reg;
    logic                               fin_neg_reg;
    logic signed [FIN_W-1:0]            fin_sh;
    logic signed [P_W-1:0]              s30_reg;
    logic signed [P_W-1:0]              c30_reg;
    logic signed [scp_pkg::RESULT_W-1:0] sine_reg;
    logic signed [scp_pkg::RESULT_W-1:0] cosine_reg;

    // Round Q2.30 to the output format and clamp to 32 bits
    function automatic logic signed [scp_pkg::RESULT_W-1:0] to_output(
        input logic signed [P_W-1:0] v
    );
        logic signed [P_W:0] r;
        r = ($signed({v[P_W-1], v}) + RND_OUT) >>> OUT_SH;
        if (r > OUT_MAX)
        begin
            r = OUT_MAX;
        end
        else if (r < OUT_MIN)
        begin
            r = OUT_MIN;
        end
        return $signed(r[scp_pkg::RESULT_W-1:0]);
    endfunction

    // Move a stage when it is empty or its successor moves
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || result_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign angle_ready = en[ST_IN];

    // Advance valid bits with their beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= angle_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Capture the angle
    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            angle_reg <= angle;
        end
    end

    // Reduce modulo two pi and fold
    scp_reduce #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_reduce (
        .clk    (clk),
        .en     (en[ST_RED +: 5]),
        .angle  (angle_reg),
        .folded (folded)
    );

    // Round the square and seed both polynomials with their leading coefficient
    always_comb
    begin
        t_wide        = (sq_reg + RND_SQ) >>> 30;
        h0_next.t     = $signed(t_wide[T_W-1:0]);
        h0_next.p_sin = P_W'(scp_pkg::sin_coef(0));
        h0_next.p_cos = P_W'(scp_pkg::cos_coef(0));
        h0_next.a30   = sq_side_reg.a30;
        h0_next.neg   = sq_side_reg.neg;
    end

    // Square the folded angle, then start the Horner chain
    always_ff @(posedge clk)
    begin
        if (en[ST_SQ])
        begin
            sq_reg      <= folded.a30 * folded.a30;
            sq_side_reg <= folded;
        end
        if (en[ST_T])
        begin
            h[0] <= h0_next;
        end
    end

    // Horner steps, two stages each
    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        scp_horner_step #(
            .STEP(s + 1)
        ) u_step (
            .clk (clk),
            .en  (en[ST_H0 + 2*s +: 2]),
            .d   (h[s]),
            .q   (h[s+1])
        );
    end

    assign fin_sh = (fin_prod_reg + RND_FIN) >>> 30;

    // Multiply sine by the angle, apply the cosine sign, convert and hold the result
    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            fin_prod_reg <= h[STEPS].a30 * h[STEPS].p_sin;
            fin_cos_reg  <= h[STEPS].p_cos;
            fin_neg_reg  <= h[STEPS].neg;
        end
        if (en[ST_S30])
        begin
            s30_reg <= $signed(fin_sh[P_W-1:0]);
            c30_reg <= fin_neg_reg ? -fin_cos_reg : fin_cos_reg;
        end
        if (en[ST_OUT])
        begin
            sine_reg   <= to_output(s30_reg);
            cosine_reg <= to_output(c30_reg);
        end
    end

    assign result_valid = v_reg[ST_OUT];
    assign sine         = sine_reg;
    assign cosine       = cosine_reg;

endmodule
`default_nettype wire

FILE: sv/scp_reduce.sv
`default_nettype none
module scp_reduce #(
    parameter int ANGLE_FRAC_BITS = scp_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic [4:0]                          en,
    input  wire logic signed [scp_pkg::ANGLE_W-1:0]  angle,
    output scp_pkg::scp_angle_t                      folded
);

    localparam int SHIFT  = scp_pkg::ANGLE_W - ANGLE_FRAC_BITS;
    localparam int MOD_W  = scp_pkg::MOD_W;
    localparam int PSUM_W = scp_pkg::PSUM_W;
    localparam int SUM_W  = scp_pkg::SUM_W;
    localparam int RED3_W = scp_pkg::RED3_W;

    localparam logic [SUM_W-1:0] M1  = SUM_W'(scp_pkg::TWO_PI_Q32);
    localparam logic [SUM_W-1:0] M2  = M1 << 1;
    localparam logic [SUM_W-1:0] M4  = M1 << 2;
    localparam logic [SUM_W-1:0] M8  = M1 << 3;
    localparam logic [SUM_W-1:0] M16 = M1 << 4;

    localparam logic signed [MOD_W:0] PI_S     = $signed({1'b0, scp_pkg::PI_Q32});
    localparam logic signed [MOD_W:0] TWO_PI_S = $signed({1'b0, scp_pkg::TWO_PI_Q32});
    localparam logic signed [MOD_W:0] RND_Q30  = (MOD_W+1)'(2);

    logic [MOD_W-1:0]  term [scp_pkg::ANGLE_W];
    logic [PSUM_W-1:0] psum_next [4];
    logic [PSUM_W-1:0] psum_reg  [4];
    logic [SUM_W-1:0]  total_reg;
    logic [SUM_W-1:0]  red3_wide;
    logic [RED3_W-1:0] red3_reg;
    logic [SUM_W-1:0]  r_wide;
    logic [MOD_W-1:0]  r_reg;
    logic signed [MOD_W:0] r_s;
    logic signed [MOD_W:0] a;
    logic signed [MOD_W:0] a_rnd;
    scp_pkg::scp_angle_t folded_next;
    scp_pkg::scp_angle_t folded_reg;

    // Map each angle bit below the sign bit to its residue of 2^(bit + SHIFT) modulo two pi
    for (genvar i = 0; i < scp_pkg::ANGLE_W - 1; i++)
    begin : g_term
        localparam logic [MOD_W-1:0] RES = scp_pkg::pow2_mod(i + SHIFT);
        assign term[i] = angle[i] ? RES : '0;
    end

    // Sign bit weighs -2^(31 + SHIFT): use the complementary residue
    localparam logic [MOD_W-1:0] RES_SIGN = scp_pkg::pow2_mod(scp_pkg::ANGLE_W - 1 + SHIFT);
    localparam logic [MOD_W-1:0] NEG_SIGN =
        (RES_SIGN == '0) ? '0 : scp_pkg::TWO_PI_Q32 - RES_SIGN;
    assign term[scp_pkg::ANGLE_W-1] = angle[scp_pkg::ANGLE_W-1] ? NEG_SIGN : '0;

    // Add residues in four groups of eight
    always_comb
    begin
        for (int g = 0; g < 4; g++)
        begin
            psum_next[g] = '0;
            for (int j = 0; j < 8; j++)
            begin
                psum_next[g] = psum_next[g] + PSUM_W'(term[8*g + j]);
            end
        end
    end

    // Trim the sum below four times two pi
    always_comb
    begin
        red3_wide = total_reg;
        if (red3_wide >= M16)
        begin
            red3_wide = red3_wide - M16;
        end
        if (red3_wide >= M8)
        begin
            red3_wide = red3_wide - M8;
        end
        if (red3_wide >= M4)
        begin
            red3_wide = red3_wide - M4;
        end
    end

    // Finish the remainder in [0, 2pi)
    always_comb
    begin
        r_wide = SUM_W'(red3_reg);
        if (r_wide >= M2)
        begin
            r_wide = r_wide - M2;
        end
        if (r_wide >= M1)
        begin
            r_wide = r_wide - M1;
        end
    end

    // Fold into [-pi/2, pi/2] and round to Q2.30
    always_comb
    begin
        r_s             = $signed({1'b0, r_reg});
        folded_next.neg = 1'b0;
        if (r_reg < scp_pkg::PI_Q32)
        begin
            if (r_reg > scp_pkg::HALF_PI_Q32)
            begin
                a               = PI_S - r_s;
                folded_next.neg = 1'b1;
            end
            else
            begin
                a = r_s;
            end
        end
        else
        begin
            if (r_reg > scp_pkg::THREE_HALF_PI_Q32)
            begin
                a = r_s - TWO_PI_S;
            end
            else
            begin
                a               = PI_S - r_s;
                folded_next.neg = 1'b1;
            end
        end
        a_rnd           = (a + RND_Q30) >>> 2;
        folded_next.a30 = $signed(a_rnd[scp_pkg::Q30_W-1:0]);
    end

    // Advance the reduction stages
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            psum_reg <= psum_next;
        end
        if (en[1])
        begin
            total_reg <= SUM_W'(psum_reg[0]) + SUM_W'(psum_reg[1])
                       + SUM_W'(psum_reg[2]) + SUM_W'(psum_reg[3]);
        end
        if (en[2])
        begin
            red3_reg <= red3_wide[RED3_W-1:0];
        end
        if (en[3])
        begin
            r_reg <= r_wide[MOD_W-1:0];
        end
        if (en[4])
        begin
            folded_reg <= folded_next;
        end
    end

    assign folded = folded_reg;

endmodule
`default_nettype wire

FILE: sv/scp_horner_step.sv
`default_nettype none
module scp_horner_step #(
    parameter int STEP = 1
) (
    input  wire logic                 clk,
    input  wire logic [1:0]           en,
    input  wire scp_pkg::scp_horner_t d,
    output scp_pkg::scp_horner_t      q
);

    localparam int P_W    = scp_pkg::P_W;
    localparam int PROD_W = scp_pkg::P_W + scp_pkg::T_W;

    localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) <<< 29;
    localparam logic signed [P_W-1:0] C_SIN = P_W'(scp_pkg::sin_coef(STEP));
    localparam logic signed [P_W-1:0] C_COS = P_W'(scp_pkg::cos_coef(STEP));

    logic signed [PROD_W-1:0] prod_sin_reg;
    logic signed [PROD_W-1:0] prod_cos_reg;
    scp_pkg::scp_horner_t     side_reg;
    logic signed [PROD_W-1:0] sh_sin;
    logic signed [PROD_W-1:0] sh_cos;
    scp_pkg::scp_horner_t     q_next;
    scp_pkg::scp_horner_t     q_reg;

    // Round both products to Q2.30 and add the next coefficient
    always_comb
    begin
        sh_sin       = (prod_sin_reg + RND) >>> 30;
        sh_cos       = (prod_cos_reg + RND) >>> 30;
        q_next       = side_reg;
        q_next.p_sin = $signed(sh_sin[P_W-1:0]) + C_SIN;
        q_next.p_cos = $signed(sh_cos[P_W-1:0]) + C_COS;
    end

    // Multiply in the first stage, accumulate in the second
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_sin_reg <= d.p_sin * d.t;
            prod_cos_reg <= d.p_cos * d.t;
            side_reg     <= d;
        end
        if (en[1])
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

FILE: sv/scp_checker.sv
`default_nettype none
`include "sine_cosine_polynomial_assert.svh"
module scp_checker #(
    parameter int RESULT_FRAC_BITS = scp_pkg::RESULT_FRAC_BITS_DEF
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                angle_valid,
    input wire logic                                angle_ready,
    input wire logic                                result_valid,
    input wire logic                                result_ready,
    input wire logic signed [scp_pkg::RESULT_W-1:0] sine,
    input wire logic signed [scp_pkg::RESULT_W-1:0] cosine
);

    // Unit magnitude plus a small margin for polynomial error
    localparam logic signed [scp_pkg::RESULT_W:0] LIM =
        ((scp_pkg::RESULT_W+1)'(1) <<< RESULT_FRAC_BITS)
        + ((scp_pkg::RESULT_W+1)'(1) <<< (RESULT_FRAC_BITS - 8));

    // Hold a stalled result beat
    `SCP_ASSERT_NEXT(a_stall_hold, result_valid && !result_ready, result_valid && $stable(sine) && $stable(cosine))

    // Take a new angle whenever the output side can drain
    `SCP_ASSERT_IMPLY(a_ready_drain, !result_valid || result_ready, angle_ready)

    // Keep both results within unit magnitude plus the margin
    `SCP_ASSERT_IMPLY(a_sine_range, result_valid, (sine <= LIM) && (sine >= -LIM))
    `SCP_ASSERT_IMPLY(a_cosine_range, result_valid && angle_valid | !angle_valid, (cosine <= LIM) && (cosine >= -LIM))

endmodule

bind sine_cosine_polynomial scp_checker #(
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
) u_scp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .angle_valid  (angle_valid),
    .angle_ready  (angle_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sine         (sine),
    .cosine       (cosine)
);
`default_nettype wire
